// ===== sv/prim_mst_pkg.sv =====
// Package for the Prim spanning tree block: sizes, command and result codes,
// controller states. No dependencies.
`default_nettype none
package prim_mst_pkg;

	localparam int unsigned MAX_VERTICES = 32;
	// Vertex numbers the edge fields can carry are below 32.
	localparam int unsigned NMAX    = (MAX_VERTICES < 32) ? MAX_VERTICES : 32;
	localparam int unsigned VTX_W   = $clog2(MAX_VERTICES);
	localparam int unsigned ADDR_W  = 2 * VTX_W;
	localparam int unsigned DEPTH   = 1 << ADDR_W;

	localparam int unsigned VFIELD_W = 5;
	localparam int unsigned COST_W   = 10;
	localparam int unsigned TOTAL_W  = 15;
	localparam int unsigned COUNT_W  = 6;
	localparam int unsigned KIND_W   = 3;
	localparam int unsigned CMD_W    = 2;

	localparam logic [COST_W-1:0] NO_EDGE    = 10'd1023;
	localparam logic [COST_W-1:0] COST_LIMIT = 10'd999;

	localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RUN   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	localparam logic [KIND_W-1:0] K_STORED   = 3'd0;
	localparam logic [KIND_W-1:0] K_REJECTED = 3'd1;
	localparam logic [KIND_W-1:0] K_TREE     = 3'd2;
	localparam logic [KIND_W-1:0] K_UNREACH  = 3'd3;
	localparam logic [KIND_W-1:0] K_EMPTY    = 3'd4;
	localparam logic [KIND_W-1:0] K_CLEARED  = 3'd5;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADD_RD_AB,
		ST_ADD_WR_AB,
		ST_ADD_RD_BA,
		ST_ADD_WR_BA,
		ST_SCAN,
		ST_SCAN_END,
		ST_DECIDE
	} state_t;

endpackage
`default_nettype wire

// ===== sv/prim_mst_ram.sv =====
// Generic single-port RAM, registered read, one access per cycle.
// No dependencies.
`default_nettype none
module prim_mst_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    addr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule
`default_nettype wire

// ===== sv/prim_minimum_spanning_tree_core.sv =====
// Prim minimum spanning tree core; uses prim_mst_pkg and prim_mst_ram.
// Add edge: read-modify-write of both matrix entries. Clear: fills with "no edge".
// Run with n vertices: each tree edge scans all n*n matrix entries, one matrix read
// a cycle over the single RAM port; fewer than 2 vertices: an empty result.
// After reset a sweep writes "no edge" to every matrix word; busy stays high meanwhile.
// Results are strobed for one cycle each; the receiver cannot stall.
`default_nettype none
module prim_minimum_spanning_tree_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic [prim_mst_pkg::CMD_W-1:0]      cmd,
	input  wire logic [prim_mst_pkg::VFIELD_W-1:0]   edge_from,
	input  wire logic [prim_mst_pkg::VFIELD_W-1:0]   edge_to,
	input  wire logic [prim_mst_pkg::COST_W-1:0]     edge_cost,
	input  wire logic                                cfg_we,
	input  wire logic [prim_mst_pkg::COUNT_W-1:0]    cfg_wdata,
	output logic                                     strobe,
	output logic      [prim_mst_pkg::KIND_W-1:0]     kind,
	output logic      [prim_mst_pkg::VFIELD_W-1:0]   tree_from,
	output logic      [prim_mst_pkg::VFIELD_W-1:0]   tree_to,
	output logic      [prim_mst_pkg::COST_W-1:0]     tree_cost,
	output logic      [prim_mst_pkg::TOTAL_W-1:0]    total_cost,
	output logic                                     last
);
	import prim_mst_pkg::*;

	state_t state_q, state_d;

	// configuration
	logic [COUNT_W-1:0] vcount_q;
	logic [COUNT_W-1:0] n_eff;

	// latched edge item
	logic [VTX_W-1:0]  from_q, to_q;
	logic [COST_W-1:0] cost_q;

	// clear sweep
	logic [ADDR_W-1:0] clr_addr_q;
	logic              clr_report_q;

	// run state
	logic [MAX_VERTICES-1:0] reached_q;
	logic [TOTAL_W-1:0]      total_q;
	logic [VTX_W-1:0]        cnt_q;
	logic [VTX_W-1:0]        scan_i_q, scan_j_q;
	logic                    v_s1;
	logic [VTX_W-1:0]        i_s1, j_s1;
	logic [COST_W-1:0]       best_q;
	logic [VTX_W-1:0]        bi_q, bj_q;
	logic                    found_q;
	logic                    best_clr;
	logic [TOTAL_W-1:0]      total_next;
	logic                    last_edge;

	// matrix RAM
	logic              ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [COST_W-1:0] ram_wdata, ram_rdata;

	// result
	logic              emit;
	logic [KIND_W-1:0] emit_kind;
	logic              emit_tree;
	logic              emit_total;

	logic accept;
	logic in_range;
	logic scan_row_end, scan_col_end;

	assign accept   = start && (state_q == ST_IDLE);
	assign busy     = (state_q != ST_IDLE);
	assign n_eff    = (vcount_q > COUNT_W'(NMAX)) ? COUNT_W'(NMAX) : vcount_q;
	assign in_range = (COUNT_W'(edge_from) < n_eff) && (COUNT_W'(edge_to) < n_eff);

	assign scan_col_end = (COUNT_W'(scan_j_q) == n_eff - COUNT_W'(1));
	assign scan_row_end = (COUNT_W'(scan_i_q) == n_eff - COUNT_W'(1));
	assign last_edge    = ((COUNT_W'(cnt_q) + COUNT_W'(2)) == n_eff);
	assign total_next   = total_q + TOTAL_W'(best_q);

	prim_mst_ram #(
		.WIDTH (COST_W),
		.DEPTH (DEPTH)
	) u_matrix (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, RAM access, result selection
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_addr  = {scan_i_q, scan_j_q};
		ram_wdata = cost_q;
		emit      = 1'b0;
		emit_kind = K_REJECTED;
		emit_tree = 1'b0;
		emit_total = 1'b0;
		best_clr  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_addr_q;
				ram_wdata = NO_EDGE;
				if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
					emit      = clr_report_q;
					emit_kind = K_CLEARED;
					state_d   = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					case (cmd)
						CMD_ADD: begin
							if (in_range) begin
								state_d = ST_ADD_RD_AB;
							end else begin
								emit      = 1'b1;
								emit_kind = K_REJECTED;
							end
						end
						CMD_RUN: begin
							if (n_eff < COUNT_W'(2)) begin
								emit      = 1'b1;
								emit_kind = K_EMPTY;
							end else begin
								best_clr = 1'b1;
								state_d  = ST_SCAN;
							end
						end
						CMD_CLEAR: begin
							state_d = ST_CLEAR;
						end
						default: begin
							emit      = 1'b1;
							emit_kind = K_REJECTED;
						end
					endcase
				end
			end
			ST_ADD_RD_AB: begin
				ram_addr = {from_q, to_q};
				state_d  = ST_ADD_WR_AB;
			end
			ST_ADD_WR_AB: begin
				ram_addr = {from_q, to_q};
				ram_we   = (cost_q < ram_rdata);
				state_d  = ST_ADD_RD_BA;
			end
			ST_ADD_RD_BA: begin
				ram_addr = {to_q, from_q};
				state_d  = ST_ADD_WR_BA;
			end
			ST_ADD_WR_BA: begin
				ram_addr  = {to_q, from_q};
				ram_we    = (cost_q < ram_rdata);
				emit      = 1'b1;
				emit_kind = K_STORED;
				state_d   = ST_IDLE;
			end
			ST_SCAN: begin
				ram_addr = {scan_i_q, scan_j_q};
				if (scan_col_end && scan_row_end) begin
					state_d = ST_SCAN_END;
				end
			end
			ST_SCAN_END: begin
				// last matrix word is compared in this cycle
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				emit       = 1'b1;
				emit_total = 1'b1;
				if (found_q) begin
					emit_kind = K_TREE;
					emit_tree = 1'b1;
					if (last_edge) begin
						state_d = ST_IDLE;
					end else begin
						best_clr = 1'b1;
						state_d  = ST_SCAN;
					end
				end else begin
					emit_kind = K_UNREACH;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q     <= '0;
			clr_addr_q   <= '0;
			clr_report_q <= 1'b0;
			reached_q    <= '0;
			total_q      <= '0;
			cnt_q        <= '0;
			scan_i_q     <= '0;
			scan_j_q     <= '0;
			v_s1         <= 1'b0;
			found_q      <= 1'b0;
			strobe       <= 1'b0;
		end else begin
			if (cfg_we) begin
				vcount_q <= cfg_wdata;
			end
			v_s1   <= (state_q == ST_SCAN);
			strobe <= emit;

			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
			end
			if (accept && cmd == CMD_CLEAR) begin
				clr_addr_q   <= '0;
				clr_report_q <= 1'b1;
			end

			if (accept && cmd == CMD_RUN) begin
				reached_q <= MAX_VERTICES'(1);
				total_q   <= '0;
				cnt_q     <= '0;
			end

			if (best_clr) begin
				scan_i_q <= '0;
				scan_j_q <= '0;
			end else if (state_q == ST_SCAN) begin
				if (scan_col_end) begin
					scan_j_q <= '0;
					scan_i_q <= scan_i_q + VTX_W'(1);
				end else begin
					scan_j_q <= scan_j_q + VTX_W'(1);
				end
			end

			if (state_q == ST_DECIDE && found_q) begin
				reached_q[bj_q] <= 1'b1;
				total_q         <= total_next;
				cnt_q           <= cnt_q + VTX_W'(1);
			end

			// running minimum; strict less keeps the lowest row, then column
			if (best_clr) begin
				found_q <= 1'b0;
			end else if (v_s1 && reached_q[i_s1] && !reached_q[j_s1]
					&& ram_rdata < best_q) begin
				found_q <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			from_q <= VTX_W'(edge_from);
			to_q   <= VTX_W'(edge_to);
			cost_q <= edge_cost;
		end
		i_s1 <= scan_i_q;
		j_s1 <= scan_j_q;
		if (best_clr) begin
			best_q <= COST_LIMIT;
			bi_q   <= '0;
			bj_q   <= '0;
		end else if (v_s1 && reached_q[i_s1] && !reached_q[j_s1]
				&& ram_rdata < best_q) begin
			best_q <= ram_rdata;
			bi_q   <= i_s1;
			bj_q   <= j_s1;
		end
		if (emit) begin
			kind       <= emit_kind;
			tree_from  <= emit_tree ? VFIELD_W'(bi_q) : '0;
			tree_to    <= emit_tree ? VFIELD_W'(bj_q) : '0;
			tree_cost  <= emit_tree ? best_q : '0;
			total_cost <= emit_total ? (emit_tree ? total_next : total_q) : '0;
			last       <= emit_tree ? last_edge : 1'b1;
		end
	end

endmodule
`default_nettype wire
